// ----- hw/rtl/sgb_pkg.sv -----
// ---------------------------------------------------------------------------
// sgb_pkg: shared types and constants of the scanline/grain backdrop pixel
// Payload structs, configuration layout, register indexes and the fixed
// pattern constants of the backdrop generator.
// ---------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

	// Coordinate width and derived widths
	localparam int COORD_BITS = 11;
	localparam int COLOR_BITS = 16;
	localparam int DIV_BITS   = COORD_BITS + 4;       // row*11 + left*3 fits here
	localparam int REM_STAGES = (DIV_BITS + 1) / 2;   // two dividend bits per stage
	localparam int DIV_PAD    = 2 * REM_STAGES;

	// Pattern constants
	localparam int SCAN_PERIOD   = 8;
	localparam int SCAN_OFFSET   = 3;
	localparam int GRAIN_PERIOD  = 17;
	localparam int GRAIN_OFFSET  = 5;
	localparam int GRAIN_ROW_MUL = 11;
	localparam int GRAIN_COL_MUL = 3;
	localparam logic [7:0] SCAN_AMOUNT  = 8'd18;
	localparam logic [7:0] GRAIN_AMOUNT = 8'd30;

	// Reciprocal multiply for the row offset modulo the grain period
	localparam int M17_SHIFT = COORD_BITS + 5;
	localparam int M17_MUL   = (2 ** M17_SHIFT + GRAIN_PERIOD - 1) / GRAIN_PERIOD;
	localparam int M17_PW    = COORD_BITS + M17_SHIFT;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BG_COLOR     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCENT_COLOR = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_LEFT    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_TOP     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_HEIGHT  = 3'd5;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_col;
		logic [COORD_BITS-1:0] pixel_row;
	} sgb_req_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  in_rect;
	} sgb_rsp_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] bg_color;
		logic [COLOR_BITS-1:0] accent_color;
		logic [COORD_BITS-1:0] rect_left;
		logic [COORD_BITS-1:0] rect_top;
		logic [COORD_BITS-1:0] rect_width;
		logic [COORD_BITS-1:0] rect_height;
	} sgb_cfg_t;

	localparam sgb_cfg_t CFG_RESET = '{
		bg_color:     16'h1126,
		accent_color: 16'h2A69,
		rect_left:    '0,
		rect_top:     '0,
		rect_width:   COORD_BITS'(240),
		rect_height:  COORD_BITS'(320)
	};

	// Per-pixel flags that ride along with the dividend
	typedef struct packed {
		logic                  in_rect;
		logic                  scan;
		logic                  grain_row;
		logic [COORD_BITS-1:0] col;
	} sgb_side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sgb_geom.sv -----
// ---------------------------------------------------------------------------
// sgb_geom: rectangle test and row classification
// Three stages: bounds, row offset and scanline flag, reciprocal multiply for
// the grain period, then the grain row flag.
// ---------------------------------------------------------------------------
`default_nettype none

module sgb_geom
	import sgb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                req_valid,
	input  wire sgb_req_t            req,
	input  wire sgb_cfg_t            cfg,
	output logic                     geom_valid,
	output sgb_side_t                side,
	output logic [DIV_BITS-1:0]      dividend
);

	logic                    valid_s1, valid_s2, valid_s3;
	logic                    inside_s1, inside_s2;
	logic                    scan_s1, scan_s2;
	logic [COORD_BITS-1:0]   col_s1, col_s2;
	logic [COORD_BITS-1:0]   dy_s1, dy_s2;
	logic [COORD_BITS-1:0]   q17_s2;
	logic [DIV_BITS-1:0]     div_s1, div_s2, div_s3;
	sgb_side_t               side_s3;

	logic [COORD_BITS:0]     col_end, row_end;
	logic                    inside_c;
	logic [COORD_BITS-1:0]   dy_c;
	logic [DIV_BITS-1:0]     div_c;
	logic [M17_PW-1:0]       prod_c;
	logic [COORD_BITS-1:0]   r17_c;

	// Bounds at full precision, row offset and grain dividend
	always_comb begin
		col_end  = (COORD_BITS+1)'(cfg.rect_left) + (COORD_BITS+1)'(cfg.rect_width);
		row_end  = (COORD_BITS+1)'(cfg.rect_top) + (COORD_BITS+1)'(cfg.rect_height);
		inside_c = (cfg.rect_width != '0) && (cfg.rect_height != '0) &&
			(req.pixel_col >= cfg.rect_left) &&
			((COORD_BITS+1)'(req.pixel_col) < col_end) &&
			(req.pixel_row >= cfg.rect_top) &&
			((COORD_BITS+1)'(req.pixel_row) < row_end);
		dy_c     = req.pixel_row - cfg.rect_top;
		div_c    = DIV_BITS'(req.pixel_row) * DIV_BITS'(GRAIN_ROW_MUL) +
			DIV_BITS'(cfg.rect_left) * DIV_BITS'(GRAIN_COL_MUL);
	end

	// Quotient by the grain period through a reciprocal
	assign prod_c = M17_PW'(dy_s1) * M17_PW'(M17_MUL);

	// Remainder by the grain period
	assign r17_c = dy_s2 - COORD_BITS'(q17_s2 * COORD_BITS'(GRAIN_PERIOD));

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s1 <= inside_c;
			scan_s1   <= ((dy_c % COORD_BITS'(SCAN_PERIOD)) == COORD_BITS'(SCAN_OFFSET));
			col_s1    <= req.pixel_col;
			dy_s1     <= dy_c;
			div_s1    <= div_c;

			inside_s2 <= inside_s1;
			scan_s2   <= scan_s1;
			col_s2    <= col_s1;
			dy_s2     <= dy_s1;
			q17_s2    <= prod_c[M17_PW-1:M17_SHIFT];
			div_s2    <= div_s1;

			side_s3.in_rect   <= inside_s2;
			side_s3.scan      <= scan_s2;
			side_s3.grain_row <= (r17_c == COORD_BITS'(GRAIN_OFFSET));
			side_s3.col       <= col_s2;
			div_s3            <= div_s2;
		end
	end

	assign geom_valid = valid_s3;
	assign side       = side_s3;
	assign dividend   = div_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/sgb_rem_pipe.sv -----
// ---------------------------------------------------------------------------
// sgb_rem_pipe: pipelined remainder by the rectangle width
// Restoring remainder, two dividend bits per stage, most significant first.
// Pixel flags travel alongside in each stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sgb_rem_pipe
	import sgb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  geom_valid,
	input  wire sgb_side_t             side,
	input  wire logic [DIV_BITS-1:0]   dividend,
	input  wire logic [COORD_BITS-1:0] divisor,
	output logic                       rem_valid,
	output sgb_side_t                  rem_side,
	output logic [COORD_BITS-1:0]      remainder
);

	// One shift-compare-subtract step; the partial remainder stays below a nonzero divisor
	function automatic logic [COORD_BITS-1:0] rem_step(
		input logic [COORD_BITS-1:0] r,
		input logic                  b,
		input logic [COORD_BITS-1:0] d
	);
		logic [COORD_BITS:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			t = t - {1'b0, d};
		return t[COORD_BITS-1:0];
	endfunction

	logic                  valid_sn [REM_STAGES];
	sgb_side_t             side_sn  [REM_STAGES];
	logic [COORD_BITS-1:0] rem_sn   [REM_STAGES];
	logic [DIV_PAD-1:0]    bits_sn  [REM_STAGES];

	for (genvar k = 0; k < REM_STAGES; k++) begin : g_stage
		logic                  valid_in;
		sgb_side_t             side_in;
		logic [COORD_BITS-1:0] rem_in, rem_mid, rem_nx;
		logic [DIV_PAD-1:0]    bits_in;

		if (k == 0) begin : g_first
			assign valid_in = geom_valid;
			assign side_in  = side;
			assign rem_in   = '0;
			assign bits_in  = DIV_PAD'(dividend);
		end else begin : g_next
			assign valid_in = valid_sn[k-1];
			assign side_in  = side_sn[k-1];
			assign rem_in   = rem_sn[k-1];
			assign bits_in  = bits_sn[k-1];
		end

		// Consume the top two dividend bits
		assign rem_mid = rem_step(rem_in, bits_in[DIV_PAD-1], divisor);
		assign rem_nx  = rem_step(rem_mid, bits_in[DIV_PAD-2], divisor);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else if (adv) begin
				valid_sn[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_sn[k] <= side_in;
				rem_sn[k]  <= rem_nx;
				bits_sn[k] <= bits_in << 2;
			end
		end
	end

	assign rem_valid = valid_sn[REM_STAGES-1];
	assign rem_side  = side_sn[REM_STAGES-1];
	assign remainder = rem_sn[REM_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/sgb_blend.sv -----
// ---------------------------------------------------------------------------
// sgb_blend: scanline and grain tint colours
// Blends the background toward the accent per RGB565 channel with rounding.
// Two register stages: weighted sums, then the divide by 255.
// ---------------------------------------------------------------------------
`default_nettype none

module sgb_blend
	import sgb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [COLOR_BITS-1:0] bg_color,
	input  wire logic [COLOR_BITS-1:0] accent_color,
	output logic [COLOR_BITS-1:0]      scan_color,
	output logic [COLOR_BITS-1:0]      grain_color
);

	localparam int SUM_BITS = 14;   // 63*255 + 127 fits

	typedef struct packed {
		logic [SUM_BITS-1:0] r;
		logic [SUM_BITS-1:0] g;
		logic [SUM_BITS-1:0] b;
	} mix_sums_t;

	// a*(255-k) + b*k + 127 for one channel
	function automatic logic [SUM_BITS-1:0] mix_sum(
		input logic [5:0] a,
		input logic [5:0] b,
		input logic [7:0] k
	);
		return SUM_BITS'(a) * SUM_BITS'(8'd255 - k) + SUM_BITS'(b) * SUM_BITS'(k) +
			SUM_BITS'(127);
	endfunction

	// Exact floor(x/255) for the sum range
	function automatic logic [5:0] div255(input logic [SUM_BITS-1:0] x);
		logic [SUM_BITS:0] t;
		t = (SUM_BITS+1)'(x) + (SUM_BITS+1)'(1) + (SUM_BITS+1)'(x >> 8);
		return 6'(t >> 8);
	endfunction

	function automatic mix_sums_t mix565(
		input logic [COLOR_BITS-1:0] a,
		input logic [COLOR_BITS-1:0] b,
		input logic [7:0]            k
	);
		mix_sums_t s;
		s.r = mix_sum({1'b0, a[15:11]}, {1'b0, b[15:11]}, k);
		s.g = mix_sum(a[10:5], b[10:5], k);
		s.b = mix_sum({1'b0, a[4:0]}, {1'b0, b[4:0]}, k);
		return s;
	endfunction

	function automatic logic [COLOR_BITS-1:0] pack565(input mix_sums_t s);
		logic [5:0] r, g, b;
		r = div255(s.r);
		g = div255(s.g);
		b = div255(s.b);
		return {r[4:0], g, b[4:0]};
	endfunction

	mix_sums_t               scan_sum_s1, grain_sum_s1;
	logic [COLOR_BITS-1:0]   scan_s2, grain_s2;

	// Colours follow the registers; after a write they settle once the sum and pack registers have taken it
	always_ff @(posedge clk) begin
		scan_sum_s1  <= mix565(bg_color, accent_color, SCAN_AMOUNT);
		grain_sum_s1 <= mix565(bg_color, accent_color, GRAIN_AMOUNT);
		scan_s2      <= pack565(scan_sum_s1);
		grain_s2     <= pack565(grain_sum_s1);
	end

	assign scan_color  = scan_s2;
	assign grain_color = grain_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/scanline_grain_backdrop_pixel.sv -----
// Throughput: one item per cycle while no result waits under rsp_stall.
// The remainder-by-width pipeline sets the depth.
// The whole pipeline holds while a finished result waits under rsp_stall.
// Reset: clears all valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
// scanline_grain_backdrop_pixel: retro CRT backdrop pixel generator
// Per-pixel RGB565 colour of a rectangle with scanline and grain tint.
// ---------------------------------------------------------------------------
`default_nettype none

module scanline_grain_backdrop_pixel
	import sgb_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_stall,
	input  wire sgb_req_t                req,
	output logic                         rsp_valid,
	input  wire logic                    rsp_stall,
	output sgb_rsp_t                     rsp,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COLOR_BITS-1:0]   cfg_data
);

	sgb_cfg_t                cfg_q;
	logic                    adv;
	logic                    geom_valid;
	sgb_side_t               side;
	logic [DIV_BITS-1:0]     dividend;
	logic                    rem_valid;
	sgb_side_t               rem_side;
	logic [COORD_BITS-1:0]   remainder;
	logic [COLOR_BITS-1:0]   scan_color, grain_color;
	logic [COORD_BITS:0]     dot;
	logic                    dot_hit;
	sgb_rsp_t                rsp_c;
	logic                    rsp_valid_q;
	sgb_rsp_t                rsp_q;

	// Hold everything while the result register is full and stalled
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BG_COLOR:     cfg_q.bg_color     <= cfg_data;
				REG_ACCENT_COLOR: cfg_q.accent_color <= cfg_data;
				REG_RECT_LEFT:    cfg_q.rect_left    <= cfg_data[COORD_BITS-1:0];
				REG_RECT_TOP:     cfg_q.rect_top     <= cfg_data[COORD_BITS-1:0];
				REG_RECT_WIDTH:   cfg_q.rect_width   <= cfg_data[COORD_BITS-1:0];
				REG_RECT_HEIGHT:  cfg_q.rect_height  <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	sgb_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.req_valid  (req_valid),
		.req        (req),
		.cfg        (cfg_q),
		.geom_valid (geom_valid),
		.side       (side),
		.dividend   (dividend)
	);

	sgb_rem_pipe u_rem (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.geom_valid (geom_valid),
		.side       (side),
		.dividend   (dividend),
		.divisor    (cfg_q.rect_width),
		.rem_valid  (rem_valid),
		.rem_side   (rem_side),
		.remainder  (remainder)
	);

	sgb_blend u_blend (
		.clk          (clk),
		.bg_color     (cfg_q.bg_color),
		.accent_color (cfg_q.accent_color),
		.scan_color   (scan_color),
		.grain_color  (grain_color)
	);

	// Pick the colour; a grain dot wins over a scanline
	always_comb begin
		dot     = (COORD_BITS+1)'(cfg_q.rect_left) + (COORD_BITS+1)'(remainder);
		dot_hit = rem_side.grain_row && ((COORD_BITS+1)'(rem_side.col) == dot);
		rsp_c.in_rect = rem_side.in_rect;
		if (!rem_side.in_rect)
			rsp_c.pixel_color = '0;
		else if (dot_hit)
			rsp_c.pixel_color = grain_color;
		else if (rem_side.scan)
			rsp_c.pixel_color = scan_color;
		else
			rsp_c.pixel_color = cfg_q.bg_color;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= rem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- tb/scanline_grain_backdrop_pixel_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scanline_grain_backdrop_pixel_tb: backdrop pixel generator check
// Sends pixel coordinates over valid/stall with random gaps on both sides and
// compares every returned pixel against an in-bench colour calculation built
// from a shadow copy of the registers. Covers reset values, empty and extreme
// rectangles, scanline and grain rows, ignored register indexes and random
// register settings.
// ---------------------------------------------------------------------------

module scanline_grain_backdrop_pixel_tb
	import sgb_pkg::*;
();

	// Pattern of the backdrop, as specified
	localparam int unsigned SCAN_EVERY  = 8;
	localparam int unsigned SCAN_ROW    = 3;
	localparam int unsigned GRAIN_EVERY = 17;
	localparam int unsigned GRAIN_ROW   = 5;
	localparam int unsigned DOT_ROW_MUL = 11;
	localparam int unsigned DOT_COL_MUL = 3;
	localparam int unsigned SCAN_MIX    = 18;
	localparam int unsigned GRAIN_MIX   = 30;
	localparam int unsigned COORD_SPAN  = 2 ** COORD_BITS;

	// Register indexes that map to nothing
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

	localparam int LATENCY      = 4 + REM_STAGES;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PERCENT = 17;
	localparam int MAX_REPORTS  = 10;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	sgb_req_t                req = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	sgb_rsp_t                rsp;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_BG_COLOR;
	logic [COLOR_BITS-1:0]   cfg_data = '0;

	sgb_cfg_t backdrop_regs = '{
		bg_color:     16'h1126,
		accent_color: 16'h2A69,
		rect_left:    '0,
		rect_top:     '0,
		rect_width:   COORD_BITS'(240),
		rect_height:  COORD_BITS'(320)
	};
	sgb_rsp_t pending_pixels[$];
	bit       no_gaps = 1'b0;
	int       pixels_sent = 0;
	int       pixels_checked = 0;
	int       pixels_inside = 0;
	int       settings_used = 1;
	int       mismatches = 0;
	int       stray_pixels = 0;
	int       reports = 0;
	int       cycles = 0;

	scanline_grain_backdrop_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Blend one channel toward the accent, rounded
	function automatic int unsigned mix_chan(int unsigned a, int unsigned b, int unsigned k);
		return (a * (255 - k) + b * k + 127) / 255;
	endfunction

	function automatic logic [COLOR_BITS-1:0] tint565(logic [15:0] a, logic [15:0] b,
			int unsigned k);
		int unsigned r;
		int unsigned g;
		int unsigned bl;
		r  = mix_chan(a[15:11], b[15:11], k);
		g  = mix_chan(a[10:5], b[10:5], k);
		bl = mix_chan(a[4:0], b[4:0], k);
		return COLOR_BITS'((r << 11) | (g << 5) | bl);
	endfunction

	// Column of the grain dot on a row; width must be nonzero
	function automatic int unsigned grain_dot_col(sgb_cfg_t c, int unsigned row);
		int unsigned left;
		left = c.rect_left;
		return left + (row * DOT_ROW_MUL + left * DOT_COL_MUL) % c.rect_width;
	endfunction

	// Colour and inside flag of one pixel under the given registers
	function automatic sgb_rsp_t backdrop_pixel(sgb_cfg_t c, sgb_req_t p);
		int unsigned col;
		int unsigned row;
		int unsigned left;
		int unsigned top;
		int unsigned dy;
		sgb_rsp_t    r;
		col  = p.pixel_col;
		row  = p.pixel_row;
		left = c.rect_left;
		top  = c.rect_top;
		r = '0;
		r.in_rect = c.rect_width != 0 && c.rect_height != 0 &&
			col >= left && col < left + c.rect_width &&
			row >= top && row < top + c.rect_height;
		if (r.in_rect) begin
			dy = row - top;
			r.pixel_color = c.bg_color;
			if (dy % SCAN_EVERY == SCAN_ROW)
				r.pixel_color = tint565(c.bg_color, c.accent_color, SCAN_MIX);
			// grain dot wins over a scanline
			if (dy % GRAIN_EVERY == GRAIN_ROW && col == grain_dot_col(c, row))
				r.pixel_color = tint565(c.bg_color, c.accent_color, GRAIN_MIX);
		end
		return r;
	endfunction

	// Pick a pixel: mostly inside the rectangle, some on grain dots, some anywhere
	function automatic sgb_req_t pick_pixel(sgb_cfg_t c);
		int unsigned sel;
		int unsigned cspan;
		int unsigned rspan;
		int unsigned row;
		int unsigned dot;
		sgb_req_t    p;
		p.pixel_col = COORD_BITS'($urandom);
		p.pixel_row = COORD_BITS'($urandom);
		sel = $urandom_range(99);
		if (c.rect_width != 0 && c.rect_height != 0 && sel < 80) begin
			cspan = c.rect_width;
			rspan = c.rect_height;
			if (cspan > COORD_SPAN - c.rect_left)
				cspan = COORD_SPAN - c.rect_left;
			if (rspan > COORD_SPAN - c.rect_top)
				rspan = COORD_SPAN - c.rect_top;
			p.pixel_col = COORD_BITS'(c.rect_left + $urandom_range(cspan - 1));
			p.pixel_row = COORD_BITS'(c.rect_top + $urandom_range(rspan - 1));
			if (sel < 30 && rspan > GRAIN_ROW) begin
				row = c.rect_top + GRAIN_ROW +
					GRAIN_EVERY * $urandom_range((rspan - 1 - GRAIN_ROW) / GRAIN_EVERY);
				dot = grain_dot_col(c, row);
				if (dot < COORD_SPAN) begin
					p.pixel_row = COORD_BITS'(row);
					p.pixel_col = COORD_BITS'(dot);
				end
			end
		end
		return p;
	endfunction

	function automatic logic [COLOR_BITS-1:0] pick_color();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return COLOR_BITS'($urandom);
		endcase
	endfunction

	// Coordinate register value; upper data bits are random and must be dropped
	function automatic logic [COLOR_BITS-1:0] pick_coord();
		logic [COORD_BITS-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2: v = COORD_BITS'(1);
			3, 4, 5: v = COORD_BITS'($urandom_range(1, 64));
			default: v = COORD_BITS'($urandom);
		endcase
		return {COLOR_BITS'($urandom) >> COORD_BITS << COORD_BITS} | COLOR_BITS'(v);
	endfunction

	// Write one register and mirror it; caller lowers cfg_we after the last one
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [COLOR_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_BG_COLOR:     backdrop_regs.bg_color = data;
			REG_ACCENT_COLOR: backdrop_regs.accent_color = data;
			REG_RECT_LEFT:    backdrop_regs.rect_left = data[COORD_BITS-1:0];
			REG_RECT_TOP:     backdrop_regs.rect_top = data[COORD_BITS-1:0];
			REG_RECT_WIDTH:   backdrop_regs.rect_width = data[COORD_BITS-1:0];
			REG_RECT_HEIGHT:  backdrop_regs.rect_height = data[COORD_BITS-1:0];
			default: ;
		endcase
	endtask

	// Offer one item, idling first at random; valid stays high afterwards
	task automatic send_pixel(input int unsigned col, input int unsigned row);
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid       <= 1'b1;
		req.pixel_col   <= COORD_BITS'(col);
		req.pixel_row   <= COORD_BITS'(row);
		do
			@(posedge clk);
		while (req_stall);
		pixels_sent++;
	endtask

	// Stop sending and wait for every outstanding pixel
	task automatic drain_pipeline();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_pixel(0, 0);
		send_pixel(239, 319);
		send_pixel(240, 10);
		send_pixel(10, 320);
		send_pixel(2047, 2047);
		send_pixel(7, 3);
		send_pixel(grain_dot_col(backdrop_regs, 5), 5);
		send_pixel(grain_dot_col(backdrop_regs, 5) + 1, 5);
		// row 107 is both a scanline and a grain row
		send_pixel(grain_dot_col(backdrop_regs, 107), 107);
		drain_pipeline();
	endtask

	task automatic test_empty_rect();
		write_reg(REG_RECT_WIDTH, 16'd0);
		write_reg(REG_RECT_HEIGHT, 16'd5);
		cfg_we <= 1'b0;
		settings_used++;
		send_pixel(0, 0);
		send_pixel(0, 3);
		drain_pipeline();
		write_reg(REG_RECT_WIDTH, 16'd5);
		write_reg(REG_RECT_HEIGHT, 16'd0);
		cfg_we <= 1'b0;
		settings_used++;
		send_pixel(0, 0);
		send_pixel(4, 3);
		drain_pipeline();
	endtask

	task automatic test_rect_extremes();
		// rectangle runs past the coordinate range; left data truncates to 2047
		write_reg(REG_BG_COLOR, 16'hFFFF);
		write_reg(REG_ACCENT_COLOR, 16'h0000);
		write_reg(REG_RECT_LEFT, 16'hFFFF);
		write_reg(REG_RECT_TOP, 16'd0);
		write_reg(REG_RECT_WIDTH, 16'd2047);
		write_reg(REG_RECT_HEIGHT, 16'd2047);
		cfg_we <= 1'b0;
		settings_used++;
		send_pixel(2047, 0);
		send_pixel(2046, 0);
		send_pixel(2047, 3);
		drain_pipeline();
		// one-column rectangle puts every grain dot at the left edge
		write_reg(REG_BG_COLOR, 16'h0000);
		write_reg(REG_ACCENT_COLOR, 16'hFFFF);
		write_reg(REG_RECT_LEFT, 16'd0);
		write_reg(REG_RECT_WIDTH, 16'd1);
		cfg_we <= 1'b0;
		settings_used++;
		send_pixel(0, 5);
		send_pixel(0, 107);
		send_pixel(1, 5);
		send_pixel(0, 2046);
		send_pixel(0, 2047);
		drain_pipeline();
	endtask

	task automatic test_register_aliasing();
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h0000);
		write_reg(REG_RECT_TOP, 16'hF803);
		cfg_we <= 1'b0;
		settings_used++;
		send_pixel(0, 2);
		send_pixel(0, 3);
		send_pixel(0, 6);
		drain_pipeline();
	endtask

	task automatic test_random_backdrop();
		sgb_req_t p;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_BG_COLOR, pick_color());
			write_reg(REG_ACCENT_COLOR, pick_color());
			write_reg(REG_RECT_LEFT, pick_coord());
			write_reg(REG_RECT_TOP, pick_coord());
			write_reg(REG_RECT_WIDTH, pick_coord());
			write_reg(REG_RECT_HEIGHT, pick_coord());
			cfg_we <= 1'b0;
			settings_used++;
			no_gaps = (ph == 3);
			for (int i = 0; i < 100; i++) begin
				// hold off mid-phase until the pipeline is empty
				if (ph == 5 && i == 50)
					drain_pipeline();
				p = pick_pixel(backdrop_regs);
				send_pixel(p.pixel_col, p.pixel_row);
			end
			drain_pipeline();
		end
		no_gaps = 1'b0;
	endtask

	// Predict each accepted item
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			pending_pixels.push_back(backdrop_pixel(backdrop_regs, req));
	end

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_stall <= !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		sgb_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_pixels.size() == 0) begin
				stray_pixels++;
				reports++;
				if (reports <= MAX_REPORTS)
					$display("unexpected pixel: color=%h in_rect=%b", rsp.pixel_color,
						rsp.in_rect);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (want.in_rect)
					pixels_inside++;
				if (rsp.pixel_color !== want.pixel_color || rsp.in_rect !== want.in_rect) begin
					mismatches++;
					reports++;
					if (reports <= MAX_REPORTS)
						$display("pixel %0d mismatch: color exp %h got %h, in_rect exp %b got %b",
							pixels_checked, want.pixel_color, rsp.pixel_color,
							want.in_rect, rsp.in_rect);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycles,
				pending_pixels.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_empty_rect();
		test_rect_extremes();
		test_register_aliasing();
		test_random_backdrop();
		drain_pipeline();
		repeat (LATENCY + 8) @(posedge clk);
		if (pending_pixels.size() != 0)
			$display("%0d predicted pixels never returned", pending_pixels.size());
		$display("Sent %0d pixels over %0d register settings (empty, edge and random rectangles).",
			pixels_sent, settings_used);
		$display("Checked %0d results, %0d inside the rectangle; %0d mismatches, %0d stray.",
			pixels_checked, pixels_inside, mismatches, stray_pixels);
		if (mismatches == 0 && stray_pixels == 0 && pending_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
